### design/assert_macros.svh
// Assertion macros for the loader's modules; the parser is the one that uses them.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

    // Characters with a meaning of their own in the text.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    // Record type of a data record.
    localparam logic [7:0] REC_DATA = 8'h00;

    // Parser phase within a line.
    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_SKIP       = 3'd1,
        PH_HEADER     = 3'd2,
        PH_DATA       = 3'd3,
        PH_CHECKSUM   = 3'd4
    } ihex_phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_BAD_HEX  = 2'd1,
        KIND_NO_COLON = 2'd2,
        KIND_BAD_SUM  = 2'd3
    } ihex_kind_t;

    // Position of the next header byte.
    typedef enum logic [1:0] {
        HDR_COUNT   = 2'd0,
        HDR_ADDR_HI = 2'd1,
        HDR_ADDR_LO = 2'd2,
        HDR_TYPE    = 2'd3
    } ihex_hdr_pos_t;

    // A character held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] character;
    } ihex_char_t;

    // A result leaving the parser.
    typedef struct packed {
        logic        valid;
        ihex_kind_t  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } ihex_result_t;

    // A decoded hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } ihex_digit_t;

    // Decode one ASCII hex digit, upper or lower case.
    function automatic ihex_digit_t hex_decode(input logic [7:0] ch);
        ihex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d.value = ch[3:0];
        end
        else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
        begin
            d.value = ch[3:0] + 4'd9;
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### design/ihex_char_if.sv
`default_nettype none

// Character channel into the loader.
interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

`default_nettype wire

### design/ihex_rec_if.sv
`default_nettype none

// Result channel out of the loader.
interface ihex_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, output kind, output address, output data, input ready);
    modport sink (input valid, input kind, input address, input data, output ready);
endinterface

`default_nettype wire

### design/intel_hex_record_loader.sv
// A character accepted into the input register is decoded by the parser, and its result,
// if any, enters the result register when it is free; the output register frees each
// cycle it is taken. Throughput: one character per cycle while the sink takes results.
// Reset (rst_n low, asynchronous) returns the parser to line start, clears the
// error stop and empties both registers.
`default_nettype none

module intel_hex_record_loader
    import ihex_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ihex_char_if.sink  char_in,
    ihex_rec_if.source rec_out
);

    ihex_char_t   held;
    ihex_result_t result;
    logic         advance;

    // Input register.
    ihex_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .advance (advance),
        .held    (held)
    );

    // Parser state and decode.
    ihex_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .held    (held),
        .advance (advance),
        .result  (result)
    );

    // Result register.
    ihex_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .advance (advance),
        .rec_out (rec_out)
    );

endmodule

`default_nettype wire

### design/ihex_in_stage.sv
`default_nettype none

// Input register: holds one character until the parser takes it.
module ihex_in_stage
    import ihex_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ihex_char_if.sink  char_in,
    input  wire logic  advance,
    output ihex_char_t held
);

    logic       valid_reg;
    logic [7:0] char_reg;
    logic       take;

    // A new item may enter when the register is empty or is being drained.
    assign char_in.ready = !valid_reg || advance;
    assign take          = char_in.valid && char_in.ready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Character payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_in.character;
        end
    end

    assign held.valid     = valid_reg;
    assign held.character = char_reg;

endmodule

`default_nettype wire

### design/ihex_parser.sv
`default_nettype none

// Record parser: line state, header fields, running sum and the result
// for the character in the input register.
module ihex_parser
    import ihex_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ihex_char_t held,
    input  wire logic       advance,
    output ihex_result_t    result
);

    `include "assert_macros.svh"

    ihex_phase_t   phase_reg, phase_next;
    logic          have_hi_reg, have_hi_next;
    logic [3:0]    hi_nib_reg, hi_nib_next;
    ihex_hdr_pos_t hdr_pos_reg, hdr_pos_next;
    logic [7:0]    bytes_rem_reg, bytes_rem_next;
    logic [15:0]   next_addr_reg, next_addr_next;
    logic [7:0]    sum_reg, sum_next;
    logic          stopped_reg, stopped_next;

    logic          step;
    logic [7:0]    ch;
    ihex_digit_t   dig;
    logic [7:0]    byte_val;
    logic [7:0]    sum_add;
    logic          in_record;
    logic          pair_done;

    assign step      = held.valid && advance && !stopped_reg;
    assign ch        = held.character;
    assign dig       = hex_decode(ch);
    assign byte_val  = {hi_nib_reg, dig.value};
    assign sum_add   = sum_reg + byte_val;
    assign in_record = (phase_reg == PH_HEADER) || (phase_reg == PH_DATA)
                       || (phase_reg == PH_CHECKSUM);
    assign pair_done = dig.ok && have_hi_reg;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (ch == CH_NEWLINE)
                    begin
                        phase_next = PH_LINE_START;
                    end
                end
                PH_HEADER:
                begin
                    if (pair_done && hdr_pos_reg == HDR_TYPE)
                    begin
                        if (byte_val != REC_DATA)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (bytes_rem_reg == 8'd0)
                        begin
                            phase_next = PH_CHECKSUM;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (pair_done && bytes_rem_reg == 8'd1)
                    begin
                        phase_next = PH_CHECKSUM;
                    end
                end
                PH_CHECKSUM:
                begin
                    if (pair_done && sum_add == 8'd0)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                default:
                begin
                    if (ch == CH_HASH || ch == CH_SEMI)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (ch == CH_COLON)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
            endcase
        end
    end

    // Field updates and the result of this step.
    always_comb
    begin
        have_hi_next   = have_hi_reg;
        hi_nib_next    = hi_nib_reg;
        hdr_pos_next   = hdr_pos_reg;
        bytes_rem_next = bytes_rem_reg;
        next_addr_next = next_addr_reg;
        sum_next       = sum_reg;
        stopped_next   = stopped_reg;
        result.valid   = 1'b0;
        result.kind    = KIND_WRITE;
        result.address = 16'd0;
        result.data    = 8'd0;
        if (step && in_record)
        begin
            if (!dig.ok)
            begin
                // Any non-hex character inside a record is fatal.
                stopped_next = 1'b1;
                result.valid = 1'b1;
                result.kind  = KIND_BAD_HEX;
            end
            else if (!have_hi_reg)
            begin
                have_hi_next = 1'b1;
                hi_nib_next  = dig.value;
            end
            else
            begin
                have_hi_next = 1'b0;
                sum_next     = sum_add;
                if (phase_reg == PH_HEADER)
                begin
                    unique case (hdr_pos_reg)
                        HDR_COUNT:
                        begin
                            bytes_rem_next = byte_val;
                            hdr_pos_next   = HDR_ADDR_HI;
                        end
                        HDR_ADDR_HI:
                        begin
                            next_addr_next = {byte_val, 8'd0};
                            hdr_pos_next   = HDR_ADDR_LO;
                        end
                        HDR_ADDR_LO:
                        begin
                            next_addr_next = {next_addr_reg[15:8],
                                              next_addr_reg[7:0] | byte_val};
                            hdr_pos_next   = HDR_TYPE;
                        end
                        default:
                        begin
                            hdr_pos_next = HDR_COUNT;
                        end
                    endcase
                end
                else if (phase_reg == PH_DATA)
                begin
                    // Each data byte goes out as a write at once.
                    next_addr_next = next_addr_reg + 16'd1;
                    bytes_rem_next = bytes_rem_reg - 8'd1;
                    result.valid   = 1'b1;
                    result.kind    = KIND_WRITE;
                    result.address = next_addr_reg;
                    result.data    = byte_val;
                end
                else if (sum_add != 8'd0)
                begin
                    stopped_next = 1'b1;
                    result.valid = 1'b1;
                    result.kind  = KIND_BAD_SUM;
                end
            end
        end
        else if (step && phase_reg != PH_SKIP)
        begin
            // Line start: comment, record or error.
            if (ch == CH_COLON)
            begin
                hdr_pos_next   = HDR_COUNT;
                have_hi_next   = 1'b0;
                hi_nib_next    = 4'd0;
                bytes_rem_next = 8'd0;
                sum_next       = 8'd0;
            end
            else if (ch != CH_HASH && ch != CH_SEMI)
            begin
                stopped_next = 1'b1;
                result.valid = 1'b1;
                result.kind  = KIND_NO_COLON;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE_START;
            have_hi_reg   <= 1'b0;
            hi_nib_reg    <= 4'd0;
            hdr_pos_reg   <= HDR_COUNT;
            bytes_rem_reg <= 8'd0;
            next_addr_reg <= 16'd0;
            sum_reg       <= 8'd0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            have_hi_reg   <= have_hi_next;
            hi_nib_reg    <= hi_nib_next;
            hdr_pos_reg   <= hdr_pos_next;
            bytes_rem_reg <= bytes_rem_next;
            next_addr_reg <= next_addr_next;
            sum_reg       <= sum_next;
            stopped_reg   <= stopped_next;
        end
    end

    // Once stopped, the parser stays stopped and says nothing more.
    `ASSERT_CLK(a_stop_sticky, stopped_reg |=> stopped_reg, "parser left the stopped state")
    `ASSERT_NEVER(a_quiet_when_stopped, stopped_reg && result.valid, "result after stop")
    // Writes come only from data bytes, and errors always stop the parser.
    `ASSERT_NEVER(a_write_in_data,
        result.valid && result.kind == KIND_WRITE && phase_reg != PH_DATA,
        "write outside data phase")
    `ASSERT_CLK(a_error_stops,
        result.valid && result.kind != KIND_WRITE |=> stopped_reg,
        "error did not stop the parser")

endmodule

`default_nettype wire

### design/ihex_out_stage.sv
`default_nettype none

// Output register: holds one result until the sink takes it.
module ihex_out_stage
    import ihex_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ihex_result_t result,
    output logic              advance,
    ihex_rec_if.source        rec_out
);

    logic        valid_reg;
    ihex_kind_t  kind_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // The parser may step whenever this register is free or being emptied.
    assign advance = !valid_reg || rec_out.ready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= result.valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            kind_reg <= result.kind;
            addr_reg <= result.address;
            data_reg <= result.data;
        end
    end

    assign rec_out.valid   = valid_reg;
    assign rec_out.kind    = kind_reg;
    assign rec_out.address = addr_reg;
    assign rec_out.data    = data_reg;

endmodule

`default_nettype wire

### dv/ihex_loader_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the loader, parses every accepted character on its
// own and compares each result item with the oldest one it has worked out.
module ihex_loader_checker
    import ihex_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ihex_char_if        chars,
    ihex_rec_if         recs,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    typedef struct packed {
        ihex_kind_t  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } loader_out_t;

    // Results worked out but not yet seen on the output, oldest first.
    loader_out_t parsed_q[$];
    int unsigned faults;

    // Parser state kept alongside the block.
    ihex_phase_t   phase;
    logic          pair_open;
    logic [3:0]    upper_nibble;
    ihex_hdr_pos_t hdr_pos;
    logic [7:0]    bytes_left;
    logic [15:0]   write_addr;
    logic [7:0]    sum8;
    logic          halted;

    // Value of one hex digit, or -1 for any other character.
    function automatic int nibble_of(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
        begin
            return int'(ch - "0");
        end
        if (ch >= "a" && ch <= "f")
        begin
            return int'(ch - "a") + 10;
        end
        if (ch >= "A" && ch <= "F")
        begin
            return int'(ch - "A") + 10;
        end
        return -1;
    endfunction

    // An error is reported once and the parser stops for good.
    function automatic void raise_fault(input ihex_kind_t kind);
        halted = 1'b1;
        parsed_q.push_back('{kind, 16'h0000, 8'h00});
    endfunction

    // Advance the parser by one character, queueing any result it causes.
    function automatic void parse_char(input logic [7:0] ch);
        int         nib;
        logic [7:0] value;
        if (halted)
        begin
            return;
        end

        // Comment lines and the rest of finished records run to the newline.
        if (phase == PH_SKIP)
        begin
            if (ch == CH_NEWLINE)
            begin
                phase = PH_LINE_START;
            end
            return;
        end

        // First character of a line.
        if (phase != PH_HEADER && phase != PH_DATA && phase != PH_CHECKSUM)
        begin
            if (ch == CH_HASH || ch == CH_SEMI)
            begin
                phase = PH_SKIP;
                return;
            end
            if (ch != CH_COLON)
            begin
                raise_fault(KIND_NO_COLON);
                return;
            end
            phase        = PH_HEADER;
            hdr_pos      = HDR_COUNT;
            pair_open    = 1'b0;
            upper_nibble = 4'h0;
            bytes_left   = 8'h00;
            sum8         = 8'h00;
            return;
        end

        // Inside a record every character must be a hex digit.
        nib = nibble_of(ch);
        if (nib < 0)
        begin
            raise_fault(KIND_BAD_HEX);
            return;
        end
        if (!pair_open)
        begin
            pair_open    = 1'b1;
            upper_nibble = nib[3:0];
            return;
        end
        pair_open = 1'b0;
        value     = {upper_nibble, nib[3:0]};
        sum8      = sum8 + value;

        if (phase == PH_HEADER)
        begin
            case (hdr_pos)
                HDR_COUNT:
                begin
                    bytes_left = value;
                    hdr_pos    = HDR_ADDR_HI;
                end
                HDR_ADDR_HI:
                begin
                    write_addr = {value, 8'h00};
                    hdr_pos    = HDR_ADDR_LO;
                end
                HDR_ADDR_LO:
                begin
                    write_addr[7:0] = value;
                    hdr_pos         = HDR_TYPE;
                end
                default:
                begin
                    hdr_pos = HDR_COUNT;
                    if (value != REC_DATA)
                    begin
                        phase = PH_SKIP;
                    end
                    else if (bytes_left == 8'h00)
                    begin
                        phase = PH_CHECKSUM;
                    end
                    else
                    begin
                        phase = PH_DATA;
                    end
                end
            endcase
            return;
        end

        // Each data byte goes out as a write; the address wraps at 16 bits.
        if (phase == PH_DATA)
        begin
            parsed_q.push_back('{KIND_WRITE, write_addr, value});
            write_addr = write_addr + 16'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'h00)
            begin
                phase = PH_CHECKSUM;
            end
            return;
        end

        // Checksum byte: the sum over the whole record must come to zero.
        if (sum8 != 8'h00)
        begin
            raise_fault(KIND_BAD_SUM);
            return;
        end
        phase = PH_SKIP;
    endfunction

    // Sample both channels at each edge; values seen here are the ones the
    // handshake used, since all drivers update with nonblocking assignments.
    always @(posedge clk or negedge rst_n)
    begin : watch
        loader_out_t want;
        if (!rst_n)
        begin
            phase        = PH_LINE_START;
            pair_open    = 1'b0;
            upper_nibble = 4'h0;
            hdr_pos      = HDR_COUNT;
            bytes_left   = 8'h00;
            write_addr   = 16'h0000;
            sum8         = 8'h00;
            halted       = 1'b0;
            parsed_q.delete();
        end
        else
        begin
            if (chars.valid === 1'b1 && chars.ready === 1'b1)
            begin
                parse_char(chars.character);
            end
            if (recs.valid === 1'b1 && recs.ready === 1'b1)
            begin
                if (parsed_q.size() == 0)
                begin
                    faults++;
                    $display("%0t: result item with none due: kind %0d address %h data %h",
                             $time, recs.kind, recs.address, recs.data);
                end
                else
                begin
                    want = parsed_q.pop_front();
                    if (recs.kind !== want.kind)
                    begin
                        faults++;
                        $display("%0t: kind expected %0d, got %0d",
                                 $time, want.kind, recs.kind);
                    end
                    if (recs.address !== want.address)
                    begin
                        faults++;
                        $display("%0t: address expected %h, got %h",
                                 $time, want.address, recs.address);
                    end
                    if (recs.data !== want.data)
                    begin
                        faults++;
                        $display("%0t: data expected %h, got %h",
                                 $time, want.data, recs.data);
                    end
                end
            end
        end
        fail_count  <= faults;
        outstanding <= parsed_q.size();
    end

endmodule

### dv/tb_intel_hex_record_loader.sv
`timescale 1ns / 1ps

module tb_intel_hex_record_loader;
    import ihex_pkg::*;

    localparam int RANDOM_CHARS    = 950;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;

    // Traffic pattern, chosen by how far through the text the sender is.
    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH,
        FLOW_TAIL
    } traffic_t;

    // How the text ends: with one of the errors, or cleanly.
    typedef enum int {
        END_EMPTY_LINE,
        END_NO_COLON,
        END_BAD_HEX,
        END_BAD_SUM,
        END_CLEAN
    } text_end_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ihex_char_if chars();
    ihex_rec_if  recs();

    logic [7:0]  text_q[$];
    int          sent;
    int          cycles;
    int unsigned fail_count;
    int unsigned outstanding;

    intel_hex_record_loader dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (chars),
        .rec_out (recs)
    );

    ihex_loader_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .recs        (recs),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic traffic_t traffic_now();
        int n;
        n = text_q.size();
        if (n == 0 || sent * 5 / n >= 4)
        begin
            return FLOW_TAIL;
        end
        return traffic_t'(sent * 5 / n);
    endfunction

    function automatic bit sender_idles();
        traffic_t t;
        t = traffic_now();
        if (t == FLOW_SEND_GAPS)
        begin
            return $urandom_range(99) < 80;
        end
        if (t == FLOW_BOTH)
        begin
            return $urandom_range(99) < 38;
        end
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        traffic_t t;
        t = traffic_now();
        if (t == FLOW_RECV_STALLS)
        begin
            return $urandom_range(99) < 80;
        end
        if (t == FLOW_BOTH)
        begin
            return $urandom_range(99) < 38;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] any_but_newline();
        logic [7:0] b;
        b = 8'($urandom_range(254));
        if (b >= CH_NEWLINE)
        begin
            b = b + 8'd1;
        end
        return b;
    endfunction

    // Two hex digits, each in a random case.
    task automatic put_hex(input logic [7:0] b);
        text_q.push_back(hex_char(b[7:4], 1'($urandom_range(1))));
        text_q.push_back(hex_char(b[3:0], 1'($urandom_range(1))));
    endtask

    // One record line with random data; a nonzero skew spoils the checksum.
    task automatic put_record(input logic [7:0] count, input logic [15:0] addr,
                              input logic [7:0] rtype, input logic [7:0] skew,
                              input int tail);
        logic [7:0] sum;
        logic [7:0] b;
        text_q.push_back(CH_COLON);
        put_hex(count);
        put_hex(addr[15:8]);
        put_hex(addr[7:0]);
        put_hex(rtype);
        sum = count + addr[15:8] + addr[7:0] + rtype;
        repeat (count)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            put_hex(b);
        end
        b = 8'h00 - sum + skew;
        put_hex(b);
        repeat (tail)
        begin
            text_q.push_back(any_but_newline());
        end
        text_q.push_back(CH_NEWLINE);
    endtask

    // Receiver side: random stalls, plus one long hold-off early on while
    // the sender keeps going, so the block backs up into its input.
    initial
    begin : recv_side
        int hold;
        bit pressure_done;
        pressure_done = 1'b0;
        recs.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!pressure_done && rst_n && sent >= text_q.size() / 10)
            begin
                pressure_done = 1'b1;
                recs.ready <= 1'b0;
                for (hold = 0; hold < PRESSURE_CYCLES; hold++)
                begin
                    @(posedge clk);
                end
            end
            recs.ready <= !receiver_stalls();
        end
    end

    initial
    begin : stimulus
        int         pick;
        int         start;
        int         cut;
        logic [7:0] count;
        logic [7:0] b;
        logic [15:0] addr;
        text_end_t  ending;

        chars.valid     <= 1'b0;
        chars.character <= 8'h00;
        sent   = 0;

        // Directed lines: a comment holding the lowest and highest byte, then
        // a data record that runs across the top of the address space.
        text_q.push_back(CH_HASH);
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        text_q.push_back(CH_NEWLINE);
        put_record(8'd2, 16'hFFFF, REC_DATA, 8'h00, 0);

        // Mostly well-formed data records, with comments and other record types.
        // Long records only go in while there is room for them in the text.
        while (text_q.size() < RANDOM_CHARS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(24) == 0 && text_q.size() + 540 < RANDOM_CHARS)
                begin
                    count = 8'($urandom_range(255, 17));
                end
                else
                begin
                    count = 8'($urandom_range(8));
                end
                if ($urandom_range(3) == 0)
                begin
                    addr = 16'hFFF8 + 16'($urandom_range(7));
                end
                else
                begin
                    addr = 16'($urandom);
                end
                put_record(count, addr, REC_DATA, 8'h00,
                           ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0);
            end
            else if (pick < 82)
            begin
                text_q.push_back($urandom_range(1) ? CH_HASH : CH_SEMI);
                repeat ($urandom_range(6))
                begin
                    text_q.push_back(any_but_newline());
                end
                text_q.push_back(CH_NEWLINE);
            end
            else
            begin
                put_record(8'($urandom_range(4)), 16'($urandom), 8'($urandom_range(255, 1)),
                           8'($urandom), $urandom_range(6));
            end
        end

        // An error stops the block until reset, so at most one ends the text.
        ending = text_end_t'($urandom_range(4));
        start  = text_q.size();
        case (ending)
            END_EMPTY_LINE:
            begin
                text_q.push_back(CH_NEWLINE);
            end
            END_NO_COLON:
            begin
                do
                begin
                    b = 8'($urandom);
                end
                while (b == CH_COLON || b == CH_HASH || b == CH_SEMI);
                text_q.push_back(b);
            end
            END_BAD_HEX:
            begin
                // A record cut short anywhere before its last checksum digit.
                count = 8'($urandom_range(4));
                put_record(count, 16'($urandom), REC_DATA, 8'h00, 0);
                cut = $urandom_range(10 + 2 * count, 1);
                while (text_q.size() > start + cut)
                begin
                    void'(text_q.pop_back());
                end
                do
                begin
                    b = 8'($urandom);
                end
                while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
                       (b >= "a" && b <= "f"));
                text_q.push_back(b);
            end
            END_BAD_SUM:
            begin
                put_record(8'($urandom_range(4)), 16'($urandom), REC_DATA,
                           8'($urandom_range(255, 1)), 0);
            end
            default:
            begin
            end
        endcase

        // After an error the block must stay silent whatever follows.
        if (ending != END_CLEAN)
        begin
            repeat ($urandom_range(20, 4))
            begin
                text_q.push_back(8'($urandom));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Offer the text one item at a time, holding each until it is taken.
        while (sent < text_q.size())
        begin
            @(posedge clk);
            if (chars.valid === 1'b1 && chars.ready === 1'b1)
            begin
                sent++;
            end
            if (chars.valid !== 1'b1 || chars.ready === 1'b1)
            begin
                if (sent < text_q.size() && !sender_idles())
                begin
                    chars.valid     <= 1'b1;
                    chars.character <= text_q[sent];
                end
                else
                begin
                    chars.valid <= 1'b0;
                end
            end
        end

        // Wait for the last results, then a little longer for strays.
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
